/* sv/osc_ap_pkg.sv */
// Shared types and constants of the OSC argument parser.
// Used by the parser core, the result queue, the top level and the checker.
package osc_ap_pkg;

    // Default size of the type-tag store.
    localparam int MAX_TAGS_DEF = 16;

    // Result queue depth and pointer width.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int ARG_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    // Characters of the OSC type-tag string.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_INT    = 8'h69;
    localparam logic [7:0] CH_FLOAT  = 8'h66;
    localparam logic [7:0] CH_STRING = 8'h73;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SEEK,
        PH_TAGS,
        PH_TPAD,
        PH_ARG,
        PH_SPAD,
        PH_DONE
    } phase_t;

    // Codes of the known argument tags kept in the tag queue.
    typedef enum logic [1:0] {
        AC_INT    = 2'd0,
        AC_FLOAT  = 2'd1,
        AC_STRING = 2'd2
    } arg_code_t;

    // Kinds of result.
    typedef enum logic [2:0] {
        K_INT      = 3'd0,
        K_FLOAT    = 3'd1,
        K_STR_CHAR = 3'd2,
        K_STR_END  = 3'd3,
        K_MSG_END  = 3'd4,
        K_NO_TAGS  = 3'd5,
        K_TRUNC    = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ARG_W-1:0]    arg_number;
        logic [VALUE_W-1:0]  value;
        logic                final_res;
    } result_t;

    // Up to two results of one byte; a single result always sits in r0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_pair_t;

endpackage

/* sv/osc_ap_core.sv */
// Parser core of the OSC argument parser: phase machine, tag queue, word gathering.
// Depends on osc_ap_pkg.
module osc_ap_core #(
    parameter int MAX_TAGS = osc_ap_pkg::MAX_TAGS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output osc_ap_pkg::res_pair_t res
);

    localparam int IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CNT_W = $clog2(MAX_TAGS + 1);

    osc_ap_pkg::phase_t    phase_reg, phase_step, phase_next;
    logic [1:0]            align_reg, align_next, align_inc;
    logic [CNT_W-1:0]      tag_cnt_reg, tag_cnt_step, tag_cnt_next;
    logic [CNT_W-1:0]      known_cnt_reg, known_cnt_step, known_cnt_next;
    logic [1:0]            gcnt_reg, gcnt_step, gcnt_next;
    logic                  ovf_reg, ovf_step, ovf_next;
    logic [31:0]           word_reg, word_next;
    logic                  append, pop;
    logic                  is_nul, tag_known, last_known;
    osc_ap_pkg::arg_code_t new_code, head_code;
    logic [IDX_W-1:0]      head_pos;

    // Queue of known tags in order, each with its tag position.
    osc_ap_pkg::arg_code_t q_code_reg [MAX_TAGS];
    logic [IDX_W-1:0]      q_pos_reg  [MAX_TAGS];

    osc_ap_pkg::result_t   arg_res, stat_res;
    logic                  arg_v;

    assign is_nul     = (in_byte == osc_ap_pkg::CH_NUL);
    assign align_inc  = align_reg + 2'd1;
    assign head_code  = q_code_reg[0];
    assign head_pos   = q_pos_reg[0];
    assign last_known = (known_cnt_reg == CNT_W'(1));

    // Classify a tag character.
    always_comb begin
        tag_known = 1'b1;
        new_code  = osc_ap_pkg::AC_INT;
        case (in_byte)
            osc_ap_pkg::CH_INT:    new_code = osc_ap_pkg::AC_INT;
            osc_ap_pkg::CH_FLOAT:  new_code = osc_ap_pkg::AC_FLOAT;
            osc_ap_pkg::CH_STRING: new_code = osc_ap_pkg::AC_STRING;
            default:               tag_known = 1'b0;
        endcase
    end

    // Next state of the phase machine and the packet counters.
    always_comb begin
        phase_step     = phase_reg;
        align_next     = align_reg;
        tag_cnt_step   = tag_cnt_reg;
        known_cnt_step = known_cnt_reg;
        gcnt_step      = gcnt_reg;
        ovf_step       = ovf_reg;
        word_next      = word_reg;
        append         = 1'b0;
        pop            = 1'b0;
        case (phase_reg)
            osc_ap_pkg::PH_SEEK: begin
                if (in_byte == osc_ap_pkg::CH_COMMA) begin
                    phase_step     = osc_ap_pkg::PH_TAGS;
                    align_next     = 2'd1;
                    tag_cnt_step   = '0;
                    known_cnt_step = '0;
                    ovf_step       = 1'b0;
                end
            end
            osc_ap_pkg::PH_TAGS: begin
                align_next = align_inc;
                if (is_nul) begin
                    gcnt_step = 2'd0;
                    if (known_cnt_reg == '0) begin
                        phase_step = osc_ap_pkg::PH_DONE;
                    end else if (align_inc == 2'd0) begin
                        phase_step = osc_ap_pkg::PH_ARG;
                    end else begin
                        phase_step = osc_ap_pkg::PH_TPAD;
                    end
                end else if (tag_cnt_reg != CNT_W'(MAX_TAGS)) begin
                    tag_cnt_step = tag_cnt_reg + CNT_W'(1);
                    if (tag_known) begin
                        append         = 1'b1;
                        known_cnt_step = known_cnt_reg + CNT_W'(1);
                    end
                end else begin
                    ovf_step = 1'b1;
                end
            end
            osc_ap_pkg::PH_TPAD: begin
                align_next = align_inc;
                if (align_inc == 2'd0) begin
                    phase_step = osc_ap_pkg::PH_ARG;
                    gcnt_step  = 2'd0;
                end
            end
            osc_ap_pkg::PH_ARG: begin
                align_next = align_inc;
                case (head_code)
                    osc_ap_pkg::AC_INT, osc_ap_pkg::AC_FLOAT: begin
                        word_next = {word_reg[23:0], in_byte};
                        if (gcnt_reg == 2'd3) begin
                            pop            = 1'b1;
                            known_cnt_step = known_cnt_reg - CNT_W'(1);
                            gcnt_step      = 2'd0;
                            phase_step     = last_known ? osc_ap_pkg::PH_DONE
                                                        : osc_ap_pkg::PH_ARG;
                        end else begin
                            gcnt_step = gcnt_reg + 2'd1;
                        end
                    end
                    osc_ap_pkg::AC_STRING: begin
                        if (is_nul) begin
                            pop            = 1'b1;
                            known_cnt_step = known_cnt_reg - CNT_W'(1);
                            gcnt_step      = 2'd0;
                            if (last_known) begin
                                phase_step = osc_ap_pkg::PH_DONE;
                            end else if (align_inc == 2'd0) begin
                                phase_step = osc_ap_pkg::PH_ARG;
                            end else begin
                                phase_step = osc_ap_pkg::PH_SPAD;
                            end
                        end
                    end
                    default: begin
                        phase_step = osc_ap_pkg::PH_ARG;
                    end
                endcase
            end
            osc_ap_pkg::PH_SPAD: begin
                align_next = align_inc;
                if (align_inc == 2'd0) begin
                    phase_step = osc_ap_pkg::PH_ARG;
                end
            end
            default: begin
                phase_step = phase_reg;
            end
        endcase

        // The last byte returns the packet state to its idle values.
        phase_next     = phase_step;
        tag_cnt_next   = tag_cnt_step;
        known_cnt_next = known_cnt_step;
        gcnt_next      = gcnt_step;
        ovf_next       = ovf_step;
        if (in_last) begin
            phase_next     = osc_ap_pkg::PH_SEEK;
            align_next     = 2'd0;
            tag_cnt_next   = '0;
            known_cnt_next = '0;
            gcnt_next      = 2'd0;
            ovf_next       = 1'b0;
        end
    end

    // Argument result and status result of the current byte.
    always_comb begin
        arg_v              = 1'b0;
        arg_res.kind       = osc_ap_pkg::K_INT;
        arg_res.arg_number = osc_ap_pkg::ARG_W'(head_pos);
        arg_res.value      = {word_reg[23:0], in_byte};
        arg_res.final_res  = 1'b0;
        if (phase_reg == osc_ap_pkg::PH_ARG) begin
            case (head_code)
                osc_ap_pkg::AC_INT: begin
                    arg_v = (gcnt_reg == 2'd3);
                end
                osc_ap_pkg::AC_FLOAT: begin
                    arg_v        = (gcnt_reg == 2'd3);
                    arg_res.kind = osc_ap_pkg::K_FLOAT;
                end
                osc_ap_pkg::AC_STRING: begin
                    arg_v = 1'b1;
                    if (is_nul) begin
                        arg_res.kind  = osc_ap_pkg::K_STR_END;
                        arg_res.value = '0;
                    end else begin
                        arg_res.kind  = osc_ap_pkg::K_STR_CHAR;
                        arg_res.value = {24'd0, in_byte};
                    end
                end
                default: begin
                    arg_v = 1'b0;
                end
            endcase
        end

        stat_res.arg_number = '0;
        stat_res.value      = {31'd0, ovf_step};
        stat_res.final_res  = 1'b1;
        case (phase_step)
            osc_ap_pkg::PH_SEEK: stat_res.kind = osc_ap_pkg::K_NO_TAGS;
            osc_ap_pkg::PH_DONE: stat_res.kind = (tag_cnt_step == '0)
                                               ? osc_ap_pkg::K_NO_TAGS
                                               : osc_ap_pkg::K_MSG_END;
            default:             stat_res.kind = osc_ap_pkg::K_TRUNC;
        endcase

        if (arg_v) begin
            res.v0 = step;
            res.r0 = arg_res;
            res.v1 = step & in_last;
            res.r1 = stat_res;
        end else begin
            res.v0 = step & in_last;
            res.r0 = stat_res;
            res.v1 = 1'b0;
            res.r1 = stat_res;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= osc_ap_pkg::PH_SEEK;
            align_reg     <= 2'd0;
            tag_cnt_reg   <= '0;
            known_cnt_reg <= '0;
            gcnt_reg      <= 2'd0;
            ovf_reg       <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            align_reg     <= align_next;
            tag_cnt_reg   <= tag_cnt_next;
            known_cnt_reg <= known_cnt_next;
            gcnt_reg      <= gcnt_next;
            ovf_reg       <= ovf_next;
        end
    end

    // Gathered word and tag queue: appended at the tail, popped at the head.
    always_ff @(posedge aclk) begin
        if (step) begin
            word_reg <= word_next;
            for (int i = 0; i < MAX_TAGS; i++) begin
                if (append && (known_cnt_reg[IDX_W-1:0] == IDX_W'(i))) begin
                    q_code_reg[i] <= new_code;
                    q_pos_reg[i]  <= tag_cnt_reg[IDX_W-1:0];
                end else if (pop && (i < MAX_TAGS - 1)) begin
                    q_code_reg[i] <= q_code_reg[(i + 1) % MAX_TAGS];
                    q_pos_reg[i]  <= q_pos_reg[(i + 1) % MAX_TAGS];
                end
            end
        end
    end

endmodule

/* sv/osc_ap_outq.sv */
// Result queue of the OSC argument parser: takes up to two results per cycle,
// hands out one per cycle while out_ready is high. Depends on osc_ap_pkg.
module osc_ap_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  osc_ap_pkg::res_pair_t wr,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output osc_ap_pkg::result_t   out_res
);

    localparam int PW = osc_ap_pkg::OQ_PTR_W;

    osc_ap_pkg::result_t mem_reg [osc_ap_pkg::OQ_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]         count_reg, count_next;
    logic [1:0]          n_wr;
    logic                rd;

    assign n_wr      = {1'b0, wr.v0} + {1'b0, wr.v1};
    assign out_valid = (count_reg != '0);
    assign rd        = out_valid & out_ready;
    assign out_res   = mem_reg[rd_ptr_reg];

    // Two free entries are needed for the worst case of one byte.
    assign room = (count_reg <= (PW + 1)'(osc_ap_pkg::OQ_DEPTH - 2));

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(n_wr);
        rd_ptr_next = rd_ptr_reg + PW'(rd);
        count_next  = count_reg + (PW + 1)'(n_wr) - (PW + 1)'(rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (wr.v0) begin
            mem_reg[wr_ptr_reg] <= wr.r0;
        end
        if (wr.v1) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= wr.r1;
        end
    end

endmodule

/* sv/osc_argument_parser.sv */
// An accepted byte waits in the input stage; the parser step on it writes its results
// to the result queue, which drives m_*. One byte per cycle while the queue has room
// for a worst-case byte; m_* moves one request per cycle under m_tready, and a byte can yield two results.
// Reset (aresetn low, synchronous) empties the input stage and result queue and
// returns the parser to searching for the comma of a new packet.
module osc_argument_parser #(
    parameter int MAX_TAGS = osc_ap_pkg::MAX_TAGS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [osc_ap_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [osc_ap_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [3:0] arg_number, [35:4] value
    output logic [osc_ap_pkg::OUT_TUSER_W-1:0]  m_tuser,  // [2:0] kind
    output logic                                m_tlast   // final_res
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  s_acc, step, room;
    osc_ap_pkg::res_pair_t pair;
    osc_ap_pkg::result_t   out_res;

    // The input stage advances when it holds a byte and the queue can take a worst-case byte.
    assign step     = in_valid_reg & room;
    assign s_tready = ~in_valid_reg | step;
    assign s_acc    = s_tvalid & s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_acc) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    osc_ap_core #(
        .MAX_TAGS (MAX_TAGS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (pair)
    );

    osc_ap_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (pair),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the stream.
    assign m_tdata = {4'd0, out_res.value, out_res.arg_number};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.final_res;

endmodule

/* sv/osc_ap_checker.sv */
// Port-level checks of the OSC argument parser, bound to its top level.
// Depends on osc_ap_pkg and osc_argument_parser.
module osc_ap_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [osc_ap_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [osc_ap_pkg::OUT_TUSER_W-1:0]  m_tuser,
    input logic                                m_tlast
);

    // Reset leaves no result pending and the input open.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("result pending or input closed after reset");

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // The closing result of a packet is a status with argument number zero.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'd0
            && m_tdata[35:5] == 31'd0
            && (m_tuser == osc_ap_pkg::K_MSG_END
                || m_tuser == osc_ap_pkg::K_NO_TAGS
                || m_tuser == osc_ap_pkg::K_TRUNC)))
        else $error("bad packet status result");

    // Argument results are never marked final, and a character fills one byte.
    a_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> ((m_tuser == osc_ap_pkg::K_INT
                                     || m_tuser == osc_ap_pkg::K_FLOAT
                                     || m_tuser == osc_ap_pkg::K_STR_END
                                     || (m_tuser == osc_ap_pkg::K_STR_CHAR
                                         && m_tdata[35:12] == 24'd0))))
        else $error("bad argument result");

endmodule

bind osc_argument_parser osc_ap_checker u_osc_ap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/testbench.sv */
// Self-checking testbench of the OSC argument parser: directed packets, then random packets.
// Depends on osc_ap_pkg and osc_argument_parser; predicts results from its parser model or typed rows.
`timescale 1ns / 100ps

module testbench;

    localparam int ITEM_GOAL      = 1200;
    localparam int CALM_AFTER     = ITEM_GOAL - 150;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DIRECTED_ROWS  = 24;

    // Tag code for characters other than i, f and s.
    localparam logic [1:0] TAG_UNKNOWN = 2'd3;

    localparam osc_ap_pkg::result_t NO_RESULT  = '0;
    localparam osc_ap_pkg::result_t ST_NO_TAGS = '{osc_ap_pkg::K_NO_TAGS, 4'd0, 32'd0, 1'b1};
    localparam osc_ap_pkg::result_t ST_TRUNC   = '{osc_ap_pkg::K_TRUNC, 4'd0, 32'd0, 1'b1};

    typedef struct {
        logic [7:0]          data;
        logic                lst;
        logic                typed;
        osc_ap_pkg::result_t status;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [osc_ap_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                               s_tlast  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [osc_ap_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [osc_ap_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                               m_tlast;

    // Typed expectation that travels with the byte currently offered.
    logic                   row_typed  = 1'b0;
    osc_ap_pkg::result_t    row_status = '0;

    int                     bytes_in       = 0;
    int                     mismatch_count = 0;
    int                     idle_cycles    = 0;
    logic                   calm;
    logic                   held_off       = 1'b0;

    osc_ap_pkg::result_t    expected_results[$];
    osc_ap_pkg::result_t    step_results[$];
    osc_ap_pkg::result_t    got;
    logic [7:0]             pkt_bytes[$];

    // Parser model state.
    osc_ap_pkg::phase_t     prs_phase;
    logic [1:0]             align_cnt;
    logic [1:0]             tag_codes[osc_ap_pkg::MAX_TAGS_DEF];
    int                     tag_count;
    int                     arg_index;
    logic [31:0]            word_acc;
    int                     byte_cnt;
    logic                   tags_overflowed;

    // Directed packets: lone end byte, a full packet with every argument kind,
    // a packet cut inside its tags, and an empty tag string.
    stim_row_t directed_rows[DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, ST_NO_TAGS},
        '{8'h41, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_COMMA, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_INT, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_FLOAT, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_STRING, 1'b0, 1'b0, NO_RESULT},
        '{8'h78, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_NUL, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hDE, 1'b0, 1'b0, NO_RESULT},
        '{8'hAD, 1'b0, 1'b0, NO_RESULT},
        '{8'hBE, 1'b0, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h68, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_NUL, 1'b1, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_COMMA, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, ST_TRUNC},
        '{osc_ap_pkg::CH_COMMA, 1'b0, 1'b0, NO_RESULT},
        '{osc_ap_pkg::CH_NUL, 1'b1, 1'b1, ST_NO_TAGS}
    };

    assign calm = (bytes_in >= CALM_AFTER);

    osc_argument_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Parser model.
    function automatic void clear_packet_state();
        prs_phase       = osc_ap_pkg::PH_SEEK;
        align_cnt       = 2'd0;
        tag_count       = 0;
        arg_index       = 0;
        word_acc        = '0;
        byte_cnt        = 0;
        tags_overflowed = 1'b0;
    endfunction

    // Index of the first tag at or after start that carries data.
    function automatic int next_known_tag(input int start);
        int i;
        i = start;
        while (i < tag_count && i < osc_ap_pkg::MAX_TAGS_DEF && tag_codes[i] == TAG_UNKNOWN)
            i++;
        return i;
    endfunction

    // Step to the next argument with data, or finish the packet.
    function automatic void move_to_arg(input int start, input logic aligned);
        int k;
        k = next_known_tag(start);
        word_acc = '0;
        byte_cnt = 0;
        if (k >= tag_count) begin
            prs_phase = osc_ap_pkg::PH_DONE;
        end else begin
            arg_index = k;
            prs_phase = aligned ? osc_ap_pkg::PH_ARG : osc_ap_pkg::PH_SPAD;
        end
    endfunction

    // Consume one byte and leave its results in step_results.
    function automatic void parse_byte(input logic [7:0] b, input logic lst);
        logic [1:0]        code;
        osc_ap_pkg::kind_t status;
        osc_ap_pkg::kind_t word_kind;
        case (prs_phase)
            osc_ap_pkg::PH_SEEK: begin
                if (b == osc_ap_pkg::CH_COMMA) begin
                    prs_phase       = osc_ap_pkg::PH_TAGS;
                    align_cnt       = 2'd1;
                    tag_count       = 0;
                    tags_overflowed = 1'b0;
                end
            end
            osc_ap_pkg::PH_TAGS: begin
                align_cnt = align_cnt + 2'd1;
                if (b == osc_ap_pkg::CH_NUL) begin
                    if (next_known_tag(0) >= tag_count)
                        prs_phase = osc_ap_pkg::PH_DONE;
                    else if (align_cnt == 2'd0)
                        move_to_arg(0, 1'b1);
                    else
                        prs_phase = osc_ap_pkg::PH_TPAD;
                end else if (tag_count < osc_ap_pkg::MAX_TAGS_DEF) begin
                    if (b == osc_ap_pkg::CH_INT)
                        tag_codes[tag_count] = osc_ap_pkg::AC_INT;
                    else if (b == osc_ap_pkg::CH_FLOAT)
                        tag_codes[tag_count] = osc_ap_pkg::AC_FLOAT;
                    else if (b == osc_ap_pkg::CH_STRING)
                        tag_codes[tag_count] = osc_ap_pkg::AC_STRING;
                    else
                        tag_codes[tag_count] = TAG_UNKNOWN;
                    tag_count++;
                end else begin
                    tags_overflowed = 1'b1;
                end
            end
            osc_ap_pkg::PH_TPAD: begin
                align_cnt = align_cnt + 2'd1;
                if (align_cnt == 2'd0)
                    move_to_arg(0, 1'b1);
            end
            osc_ap_pkg::PH_ARG: begin
                code      = tag_codes[arg_index];
                align_cnt = align_cnt + 2'd1;
                if (code == osc_ap_pkg::AC_INT || code == osc_ap_pkg::AC_FLOAT) begin
                    word_acc = {word_acc[23:0], b};
                    if (byte_cnt == 3) begin
                        word_kind = (code == osc_ap_pkg::AC_INT) ? osc_ap_pkg::K_INT
                                                                 : osc_ap_pkg::K_FLOAT;
                        step_results.push_back('{word_kind, 4'(arg_index), word_acc, 1'b0});
                        move_to_arg(arg_index + 1, 1'b1);
                    end else begin
                        byte_cnt++;
                    end
                end else if (code == osc_ap_pkg::AC_STRING) begin
                    if (b != osc_ap_pkg::CH_NUL) begin
                        step_results.push_back('{osc_ap_pkg::K_STR_CHAR, 4'(arg_index),
                                                 {24'd0, b}, 1'b0});
                    end else begin
                        step_results.push_back('{osc_ap_pkg::K_STR_END, 4'(arg_index),
                                                 32'd0, 1'b0});
                        move_to_arg(arg_index + 1, align_cnt == 2'd0);
                    end
                end else begin
                    move_to_arg(arg_index + 1, align_cnt == 2'd0);
                end
            end
            osc_ap_pkg::PH_SPAD: begin
                align_cnt = align_cnt + 2'd1;
                if (align_cnt == 2'd0)
                    prs_phase = osc_ap_pkg::PH_ARG;
            end
            default: begin
            end
        endcase

        // The last byte always closes the packet with a status.
        if (lst) begin
            if (prs_phase == osc_ap_pkg::PH_SEEK)
                status = osc_ap_pkg::K_NO_TAGS;
            else if (prs_phase == osc_ap_pkg::PH_DONE)
                status = (tag_count == 0) ? osc_ap_pkg::K_NO_TAGS : osc_ap_pkg::K_MSG_END;
            else
                status = osc_ap_pkg::K_TRUNC;
            step_results.push_back('{status, 4'd0, {31'd0, tags_overflowed}, 1'b1});
            clear_packet_state();
        end
    endfunction

    // Random packet: mostly well formed with random content, some cut short, some noise.
    function automatic void build_packet();
        int         shape;
        int         ntags;
        int         ci;
        logic [7:0] ch;
        logic [7:0] tags[$];
        pkt_bytes.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            ch = 8'($urandom_range(0, 255));
            pkt_bytes.push_back((ch == osc_ap_pkg::CH_COMMA) ? 8'h41 : ch);
        end
        ci = pkt_bytes.size();
        pkt_bytes.push_back(osc_ap_pkg::CH_COMMA);

        // A few packets carry 14 to 20 tags, which can be more than the store holds.
        ntags = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        repeat (ntags) begin
            case ($urandom_range(0, 9))
                0, 1, 2: ch = osc_ap_pkg::CH_INT;
                3, 4:    ch = osc_ap_pkg::CH_FLOAT;
                5, 6, 7: ch = osc_ap_pkg::CH_STRING;
                default: ch = 8'($urandom_range(1, 255));
            endcase
            tags.push_back(ch);
            pkt_bytes.push_back(ch);
        end
        pkt_bytes.push_back(osc_ap_pkg::CH_NUL);
        while ((pkt_bytes.size() - ci) % 4 != 0)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));

        // Argument data in tag order; unknown tags take no bytes.
        foreach (tags[t]) begin
            if (tags[t] == osc_ap_pkg::CH_INT || tags[t] == osc_ap_pkg::CH_FLOAT) begin
                repeat (4) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (tags[t] == osc_ap_pkg::CH_STRING) begin
                repeat ($urandom_range(0, 5)) pkt_bytes.push_back(8'($urandom_range(1, 255)));
                pkt_bytes.push_back(osc_ap_pkg::CH_NUL);
                while ((pkt_bytes.size() - ci) % 4 != 0)
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));

        if (shape == 1)
            pkt_bytes = pkt_bytes[0:$urandom_range(0, pkt_bytes.size() - 1)];
    endfunction

    // Offer one byte, with an occasional idle burst before it, and wait for the request.
    task automatic offer_byte(input logic [7:0] b, input logic lst, input logic typed,
                              input osc_ap_pkg::result_t status);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tdata    <= b;
        s_tlast    <= lst;
        row_typed  <= typed;
        row_status <= status;
        s_tvalid   <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sender: reset, directed rows, random packets, then drain and report.
    initial begin
        clear_packet_state();
        foreach (tag_codes[i]) tag_codes[i] = osc_ap_pkg::AC_INT;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            offer_byte(directed_rows[r].data, directed_rows[r].lst, directed_rows[r].typed,
                       directed_rows[r].status);

        while (bytes_in < ITEM_GOAL) begin
            build_packet();
            foreach (pkt_bytes[i])
                offer_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, NO_RESULT);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off that fills the block, none at the end.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_off && bytes_in >= HOLDOFF_AT) begin
                held_off = 1'b1;
                stall    = HOLDOFF_CYCLES;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 18);
            end else begin
                stall = 0;
            end
            m_tready <= (stall == 0);
            repeat ((stall == 0) ? $urandom_range(1, 12) : stall) @(posedge aclk);
        end
    end

    // Result check first, then prediction of the byte accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{osc_ap_pkg::kind_t'(m_tuser), m_tdata[3:0], m_tdata[35:4], m_tlast};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected:", $time,
                             " kind %0d arg %0d value %h last %0d",
                             got.kind, got.arg_number, got.value, got.final_res);
                    mismatch_count++;
                end else begin
                    if (got !== expected_results[0]) begin
                        $display("%0t: expected kind %0d arg %0d value %h last %0d,", $time,
                                 expected_results[0].kind, expected_results[0].arg_number,
                                 expected_results[0].value, expected_results[0].final_res,
                                 " got kind %0d arg %0d value %h last %0d",
                                 got.kind, got.arg_number, got.value, got.final_res);
                        mismatch_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end

            if (s_tvalid && s_tready) begin
                bytes_in++;
                step_results.delete();
                parse_byte(s_tdata, s_tlast);
                if (row_typed)
                    expected_results.push_back(row_status);
                else
                    foreach (step_results[i]) expected_results.push_back(step_results[i]);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

/* osc_argument_parser.f */
sv/osc_ap_pkg.sv
sv/osc_ap_core.sv
sv/osc_ap_outq.sv
sv/osc_argument_parser.sv
sv/osc_ap_checker.sv
tb/testbench.sv
